/* rtl/hsl2rgb_pkg.sv */
// Shared types and fixed-point constants for the HSL to RGB converter.
`default_nettype none

package hsl2rgb_pkg;

    // Field widths of the items
    localparam int unsigned HUE_W    = 9;
    localparam int unsigned TENTHS_W = 10;
    localparam int unsigned LEVEL_W  = 8;

    // Fixed-point format of saturation, lightness, p, q and the ramp value
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned FXW       = FRAC_BITS + 1;
    localparam logic [FXW-1:0] FX_ONE  = FXW'(64'd1 << FRAC_BITS);
    localparam logic [FXW-1:0] FX_HALF = FXW'(64'd1 << (FRAC_BITS - 1));

    // Tenths to fixed point: (v * 2^F + 500) / 1000 as a reciprocal multiply
    localparam int unsigned XW        = FRAC_BITS + TENTHS_W;
    localparam int unsigned K_DIV1000 = XW + 10;
    localparam logic [XW:0] M_DIV1000 =
        (XW + 1)'(((64'd1 << K_DIV1000) + 64'd999) / 64'd1000);
    localparam logic [TENTHS_W-1:0] TENTHS_MAX = TENTHS_W'(1000);
    localparam logic [TENTHS_W-1:0] ROUND_1000 = TENTHS_W'(500);

    // Ramp interpolation: (d * f + 30) / 60 as a reciprocal multiply
    localparam int unsigned NW      = FRAC_BITS + 7;
    localparam int unsigned K_DIV60 = NW + 6;
    localparam logic [NW:0] M_DIV60 =
        (NW + 1)'(((64'd1 << K_DIV60) + 64'd59) / 64'd60);
    localparam logic [5:0]  ROUND_60 = 6'd30;
    localparam logic [5:0]  RAMP_SPAN = 6'd60;

    // Hue angles in degrees
    localparam logic [HUE_W-1:0] HUE_FULL  = 9'd360;
    localparam logic [HUE_W-1:0] HUE_THIRD = 9'd120;
    localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 9'd240;
    localparam logic [HUE_W-1:0] HUE_SIXTH = 9'd60;
    localparam logic [HUE_W-1:0] HUE_HALF  = 9'd180;

    // Segment of the piecewise hue ramp
    typedef enum logic [3:0] {
        SEG_RISE = 4'b0001,
        SEG_HIGH = 4'b0010,
        SEG_FALL = 4'b0100,
        SEG_LOW  = 4'b1000
    } t_ramp_seg;

    typedef struct packed {
        logic [HUE_W-1:0]    hue_degrees;
        logic [TENTHS_W-1:0] saturation_tenths;
        logic [TENTHS_W-1:0] lightness_tenths;
    } t_hsl_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } t_rgb_item;

endpackage

`default_nettype wire

/* rtl/hsl2rgb_if.sv */
// Valid/ready channel interfaces for HSL input items and RGB result items.
`default_nettype none

interface hsl2rgb_hsl_if;
    import hsl2rgb_pkg::*;

    logic      valid;
    logic      ready;
    t_hsl_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hsl2rgb_rgb_if;
    import hsl2rgb_pkg::*;

    logic      valid;
    logic      ready;
    t_rgb_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/hsl_to_rgb_converter.sv */
// HSL to RGB converter: nine-stage pipeline, one item per clock while the output is not stalled.
`default_nettype none

// Converts one HSL item (hue in degrees, saturation and lightness in tenths
// of a percent) into 8-bit red, green and blue. The block takes one item
// every clock while the output is not stalled. Each result is offered on
// the output from the last stage register and leaves when the receiver
// takes it.
// The pipeline is nine register stages; the deepest paths are the
// reciprocal multiplies that replace the divisions by 1000 and by 60 and the
// lightness-times-saturation product, each with a stage of its own. Every
// stage has its own valid bit and moves whenever the stage after it can take
// its item, so empty stages fill while a finished result waits at the output
// and a stall neither drops nor repeats an item. Hue values of 360 to 511
// wrap once; saturation and lightness above 1000 clamp to 1000.
module hsl_to_rgb_converter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    hsl2rgb_hsl_if.sink        i_hsl,
    hsl2rgb_rgb_if.source      o_rgb
);
    import hsl2rgb_pkg::*;

    localparam int unsigned NS  = 9;
    localparam int unsigned NCH = 3;
    localparam int unsigned QW  = FXW + 2;
    localparam int unsigned PW1 = 2 * XW + 1;
    localparam int unsigned PW2 = 2 * NW + 1;
    localparam int unsigned LW  = FXW + LEVEL_W;

    // Segment and interpolation weight of the hue ramp at angle t
    function automatic t_ramp_seg ramp_seg(input logic [HUE_W-1:0] t);
        t_ramp_seg seg;
        if (t < HUE_SIXTH) begin
            seg = SEG_RISE;
        end else if (t < HUE_HALF) begin
            seg = SEG_HIGH;
        end else if (t < HUE_TWO_THIRDS) begin
            seg = SEG_FALL;
        end else begin
            seg = SEG_LOW;
        end
        return seg;
    endfunction

    function automatic logic [5:0] ramp_weight(input logic [HUE_W-1:0] t);
        logic [HUE_W-1:0] back;
        logic [5:0]       w;
        back = HUE_TWO_THIRDS - t;
        if (t < HUE_SIXTH) begin
            w = t[5:0];
        end else if (t >= HUE_HALF && t < HUE_TWO_THIRDS) begin
            w = back[5:0];
        end else begin
            w = 6'd0;
        end
        return w;
    endfunction

    // Pipeline control
    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_en;

    // Stage 1: wrapped hue, clamped tenths
    logic [HUE_W-1:0]    r_hue1, n_hue1;
    logic [TENTHS_W-1:0] r_sat1, n_sat1;
    logic [TENTHS_W-1:0] r_lit1, n_lit1;
    logic                r_gray1;

    // Stage 2: fixed-point s and l
    logic [XW-1:0]    w_xs, w_xl;
    logic [PW1-1:0]   w_ps, w_pl;
    logic [FXW-1:0]   r_s2, r_l2;
    logic [HUE_W-1:0] r_hue2;
    logic             r_gray2;

    // Stage 3: l * s product
    logic [2*FXW-1:0] r_lsp3;
    logic [FXW-1:0]   r_s3, r_l3;
    logic [HUE_W-1:0] r_hue3;
    logic             r_gray3;

    // Stage 4: q
    logic [2*FXW-1:0]     w_ls_sum;
    logic [FXW-1:0]       w_ls;
    logic signed [QW-1:0] w_q_raw;
    logic [FXW-1:0]       r_q4, n_q4;
    logic [FXW-1:0]       r_l4;
    logic [HUE_W-1:0]     r_hue4;
    logic                 r_gray4;

    // Stage 5: p, ramp segment and weight per channel
    logic signed [QW-1:0] w_p_raw;
    logic [FXW-1:0]       r_p5, n_p5;
    logic [FXW-1:0]       r_q5, r_l5;
    logic                 r_gray5;
    logic [HUE_W:0]       w_tr_sum;
    logic [HUE_W-1:0]     w_t [NCH];
    t_ramp_seg            r_seg5 [NCH];
    logic [5:0]           r_f5 [NCH];

    // Stage 6: (q - p) * weight + rounding
    logic [FXW-1:0] w_d;
    logic [NW-1:0]  r_m6 [NCH];
    t_ramp_seg      r_seg6 [NCH];
    logic [FXW-1:0] r_p6, r_q6, r_l6;
    logic           r_gray6;

    // Stage 7: reciprocal product for the division by 60
    logic [PW2-1:0] r_pr7 [NCH];
    t_ramp_seg      r_seg7 [NCH];
    logic [FXW-1:0] r_p7, r_q7, r_l7;
    logic           r_gray7;

    // Stage 8: channel values
    logic [FXW-1:0] r_v8 [NCH];
    logic [FXW-1:0] n_v8 [NCH];

    // Stage 9: output levels
    logic [LW-1:0]      w_lv_sum [NCH];
    logic [LEVEL_W:0]   w_lv_raw [NCH];
    logic [LEVEL_W-1:0] r_lvl9 [NCH];

    // Let a stage load when it is empty or its item moves on
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || o_rgb.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld = {r_vld[NS-2:0], i_hsl.valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (w_en & n_vld) | (~w_en & r_vld);
        end
    end

    assign i_hsl.ready = w_en[0];
    assign o_rgb.valid = r_vld[NS-1];
    assign o_rgb.data.red_level   = r_lvl9[0];
    assign o_rgb.data.green_level = r_lvl9[1];
    assign o_rgb.data.blue_level  = r_lvl9[2];

    // Stage 1: wrap hue once, clamp saturation and lightness
    always_comb begin
        n_hue1 = (i_hsl.data.hue_degrees >= HUE_FULL) ?
                 i_hsl.data.hue_degrees - HUE_FULL : i_hsl.data.hue_degrees;
        n_sat1 = (i_hsl.data.saturation_tenths > TENTHS_MAX) ?
                 TENTHS_MAX : i_hsl.data.saturation_tenths;
        n_lit1 = (i_hsl.data.lightness_tenths > TENTHS_MAX) ?
                 TENTHS_MAX : i_hsl.data.lightness_tenths;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_hue1  <= n_hue1;
            r_sat1  <= n_sat1;
            r_lit1  <= n_lit1;
            r_gray1 <= (i_hsl.data.saturation_tenths == '0);
        end
    end

    // Stage 2: scale tenths to fixed point, divide by 1000 via reciprocal
    always_comb begin
        w_xs = (XW'(r_sat1) << FRAC_BITS) + XW'(ROUND_1000);
        w_xl = (XW'(r_lit1) << FRAC_BITS) + XW'(ROUND_1000);
        w_ps = PW1'(w_xs) * PW1'(M_DIV1000);
        w_pl = PW1'(w_xl) * PW1'(M_DIV1000);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2    <= w_ps[K_DIV1000 +: FXW];
            r_l2    <= w_pl[K_DIV1000 +: FXW];
            r_hue2  <= r_hue1;
            r_gray2 <= r_gray1;
        end
    end

    // Stage 3: multiply lightness by saturation
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_lsp3  <= (2*FXW)'(r_l2) * (2*FXW)'(r_s2);
            r_s3    <= r_s2;
            r_l3    <= r_l2;
            r_hue3  <= r_hue2;
            r_gray3 <= r_gray2;
        end
    end

    // Stage 4: round l*s and form q, clamped to 0..1
    always_comb begin
        w_ls_sum = r_lsp3 + (2*FXW)'(FX_HALF);
        w_ls     = w_ls_sum[FRAC_BITS +: FXW];
        if (r_l3 < FX_HALF) begin
            w_q_raw = signed'(QW'(r_l3) + QW'(w_ls));
        end else begin
            w_q_raw = signed'(QW'(r_l3) + QW'(r_s3) - QW'(w_ls));
        end
        if (w_q_raw < 0) begin
            n_q4 = '0;
        end else if (w_q_raw > signed'(QW'(FX_ONE))) begin
            n_q4 = FX_ONE;
        end else begin
            n_q4 = w_q_raw[FXW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_q4    <= n_q4;
            r_l4    <= r_l3;
            r_hue4  <= r_hue3;
            r_gray4 <= r_gray3;
        end
    end

    // Stage 5: p = 2l - q clamped to 0..q; hue offsets per channel
    always_comb begin
        w_p_raw = signed'((QW'(r_l4) << 1) - QW'(r_q4));
        if (w_p_raw < 0) begin
            n_p5 = '0;
        end else if (w_p_raw > signed'(QW'(r_q4))) begin
            n_p5 = r_q4;
        end else begin
            n_p5 = w_p_raw[FXW-1:0];
        end
        w_tr_sum = (HUE_W+1)'(r_hue4) + (HUE_W+1)'(HUE_THIRD);
        w_t[0] = (w_tr_sum >= (HUE_W+1)'(HUE_FULL)) ?
                 HUE_W'(w_tr_sum - (HUE_W+1)'(HUE_FULL)) : w_tr_sum[HUE_W-1:0];
        w_t[1] = r_hue4;
        w_t[2] = (r_hue4 >= HUE_THIRD) ? r_hue4 - HUE_THIRD
                                        : r_hue4 + HUE_TWO_THIRDS;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_p5    <= n_p5;
            r_q5    <= r_q4;
            r_l5    <= r_l4;
            r_gray5 <= r_gray4;
            for (int c = 0; c < NCH; c++) begin
                r_seg5[c] <= ramp_seg(w_t[c]);
                r_f5[c]   <= ramp_weight(w_t[c]);
            end
        end
    end

    // Stage 6: scale the ramp height by the weight, add half of 60
    assign w_d = r_q5 - r_p5;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int c = 0; c < NCH; c++) begin
                r_m6[c]   <= NW'(w_d) * NW'(r_f5[c]) + NW'(ROUND_60);
                r_seg6[c] <= r_seg5[c];
            end
            r_p6    <= r_p5;
            r_q6    <= r_q5;
            r_l6    <= r_l5;
            r_gray6 <= r_gray5;
        end
    end

    // Stage 7: divide by 60 via reciprocal
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            for (int c = 0; c < NCH; c++) begin
                r_pr7[c]  <= PW2'(r_m6[c]) * PW2'(M_DIV60);
                r_seg7[c] <= r_seg6[c];
            end
            r_p7    <= r_p6;
            r_q7    <= r_q6;
            r_l7    <= r_l6;
            r_gray7 <= r_gray6;
        end
    end

    // Stage 8: pick the ramp value per segment, grey when saturation is zero
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            case (r_seg7[c]) inside
                SEG_RISE, SEG_FALL: n_v8[c] = r_p7 + r_pr7[c][K_DIV60 +: FXW];
                SEG_HIGH:           n_v8[c] = r_q7;
                default:            n_v8[c] = r_p7;
            endcase
            if (r_gray7) begin
                n_v8[c] = r_l7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            for (int c = 0; c < NCH; c++) begin
                r_v8[c] <= n_v8[c];
            end
        end
    end

    // Stage 9: level = round(v * 255), capped at 255
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_lv_sum[c] = (LW'(r_v8[c]) << LEVEL_W) - LW'(r_v8[c]) + LW'(FX_HALF);
            w_lv_raw[c] = w_lv_sum[c][FRAC_BITS +: LEVEL_W + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            for (int c = 0; c < NCH; c++) begin
                r_lvl9[c] <= w_lv_raw[c][LEVEL_W] ? {LEVEL_W{1'b1}}
                                                  : w_lv_raw[c][LEVEL_W-1:0];
            end
        end
    end

    // An empty first stage always takes an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> i_hsl.ready)
        else $error("input stalled with an empty first stage");

    // p never rises above q, and q never rises above one
    a_p_below_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r_p5 <= r_q5 && r_q5 <= FX_ONE))
        else $error("p/q out of order or q above one");

    // Ramp weights stay within one sixth of a turn
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r_f5[0] <= RAMP_SPAN && r_f5[1] <= RAMP_SPAN &&
                      r_f5[2] <= RAMP_SPAN))
        else $error("ramp weight above 60");

    // Channel values stay within 0..1
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> (r_v8[0] <= FX_ONE && r_v8[1] <= FX_ONE &&
                      r_v8[2] <= FX_ONE))
        else $error("channel value above one");

endmodule

`default_nettype wire

/* bench/hsl_to_rgb_converter_tb.sv */
// Self-checking testbench for the HSL to RGB converter pipeline.
`default_nettype none

module hsl_to_rgb_converter_tb;
    import hsl2rgb_pkg::*;

    localparam int  CLK_PERIOD   = 20;
    localparam int  RESET_CYCLES = 9;
    localparam int  MAX_GAP      = 9;
    localparam int  LONG_HOLD    = 60;
    localparam int  DRAIN_CYCLES = 30;
    localparam int  PHASES       = 10;
    localparam int  PHASE_ITEMS  = 50;
    localparam int  REPORT_LIMIT = 10;
    localparam time RUN_LIMIT    = 64'd4_000_000;

    // Compute expected RGB levels and hold them in acceptance order
    class rgb_tracker;
        t_rgb_item   expected_rgb[$];
        t_hsl_item   source_hsl[$];
        int unsigned fault_count;

        function longint tenths_fixed(logic [TENTHS_W-1:0] tenths);
            longint v;
            v = tenths;
            if (v > TENTHS_MAX)
                v = TENTHS_MAX;
            return (v * (64'd1 << FRAC_BITS) + ROUND_1000) / TENTHS_MAX;
        endfunction

        // Piecewise hue ramp between the low and high values
        function longint ramp_at(longint lo, longint hi, longint deg);
            longint span;
            span = hi - lo;
            if (deg < HUE_SIXTH)
                return lo + (span * deg + ROUND_60) / RAMP_SPAN;
            if (deg < HUE_HALF)
                return hi;
            if (deg < HUE_TWO_THIRDS)
                return lo + (span * (HUE_TWO_THIRDS - deg) + ROUND_60) / RAMP_SPAN;
            return lo;
        endfunction

        function logic [LEVEL_W-1:0] level_of(longint v);
            longint r;
            r = (v * 255 + (64'd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
            return (r > 255) ? 8'd255 : LEVEL_W'(r);
        endfunction

        function t_rgb_item convert_hsl(t_hsl_item item);
            t_rgb_item rgb;
            longint    one, half, hue, sat, light, prod, hi, lo, hue_r, hue_b;
            one   = 64'd1 << FRAC_BITS;
            half  = one >>> 1;
            hue   = item.hue_degrees;
            sat   = tenths_fixed(item.saturation_tenths);
            light = tenths_fixed(item.lightness_tenths);
            if (hue >= HUE_FULL)
                hue -= HUE_FULL;
            // Grey when the raw saturation is zero
            if (item.saturation_tenths == '0) begin
                rgb.red_level   = level_of(light);
                rgb.green_level = rgb.red_level;
                rgb.blue_level  = rgb.red_level;
                return rgb;
            end
            prod = (light * sat + half) >>> FRAC_BITS;
            if (light < half)
                hi = light + prod;
            else
                hi = light + sat - prod;
            if (hi < 0)
                hi = 0;
            if (hi > one)
                hi = one;
            lo = 2 * light - hi;
            if (lo < 0)
                lo = 0;
            if (lo > hi)
                lo = hi;
            hue_r = hue + HUE_THIRD;
            if (hue_r >= HUE_FULL)
                hue_r -= HUE_FULL;
            hue_b = (hue >= HUE_THIRD) ? hue - HUE_THIRD : hue + HUE_TWO_THIRDS;
            rgb.red_level   = level_of(ramp_at(lo, hi, hue_r));
            rgb.green_level = level_of(ramp_at(lo, hi, hue));
            rgb.blue_level  = level_of(ramp_at(lo, hi, hue_b));
            return rgb;
        endfunction

        function void note_hsl(t_hsl_item item);
            expected_rgb.push_back(convert_hsl(item));
            source_hsl.push_back(item);
        endfunction

        function void check_rgb(t_rgb_item got);
            t_rgb_item want;
            t_hsl_item from;
            if (expected_rgb.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected rgb item r=%0d g=%0d b=%0d",
                             got.red_level, got.green_level, got.blue_level);
                return;
            end
            want = expected_rgb.pop_front();
            from = source_hsl.pop_front();
            if (got.red_level != want.red_level || got.green_level != want.green_level ||
                got.blue_level != want.blue_level) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("rgb mismatch h=%0d s=%0d l=%0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             from.hue_degrees, from.saturation_tenths, from.lightness_tenths,
                             want.red_level, want.green_level, want.blue_level,
                             got.red_level, got.green_level, got.blue_level);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    hsl2rgb_hsl_if hsl_ch ();
    hsl2rgb_rgb_if rgb_ch ();

    rgb_tracker tracker = new();

    // Idling controls for the sender and the receiver, set by the stimulus
    bit hsl_burst;
    bit rgb_burst;
    bit rgb_hold_pending;

    hsl_to_rgb_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hsl   (hsl_ch),
        .o_rgb   (rgb_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_hsl_item make_hsl(int hue, int sat, int light);
        t_hsl_item item;
        item.hue_degrees       = HUE_W'(hue);
        item.saturation_tenths = TENTHS_W'(sat);
        item.lightness_tenths  = TENTHS_W'(light);
        return item;
    endfunction

    // Mostly legal values, with wrapped hues and clamped levels mixed in
    function automatic int pick_tenths();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        case (roll)
            0:       return 0;
            1:       return $urandom_range(1001, 1023);
            2:       return 1000;
            3:       return $urandom_range(0, 1023);
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    function automatic t_hsl_item random_hsl();
        int hue;
        hue = ($urandom_range(0, 9) == 0) ? $urandom_range(360, 511) : $urandom_range(0, 359);
        return make_hsl(hue, pick_tenths(), pick_tenths());
    endfunction

    // Offer one item after an optional idle gap and hold it until taken; call at a falling edge
    task automatic send_hsl(input t_hsl_item item);
        int unsigned gap;
        gap = hsl_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            hsl_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        hsl_ch.valid <= 1'b1;
        hsl_ch.data  <= item;
        do @(posedge i_clk); while (!hsl_ch.ready);
        tracker.note_hsl(item);
        @(negedge i_clk);
    endtask

    task automatic wait_rgb_drained();
        while (tracker.expected_rgb.size() != 0)
            @(negedge i_clk);
    endtask

    // Receiver: stall at random, once for a long stretch
    initial begin
        int unsigned stall;
        rgb_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = rgb_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (rgb_hold_pending) begin
                rgb_hold_pending = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                rgb_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rgb_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rgb_ch.valid);
            tracker.check_rgb(rgb_ch.data);
            @(negedge i_clk);
        end
    end

    // Abort a hung run
    initial begin
        #(RUN_LIMIT);
        $display("hsl_to_rgb_converter_tb failed");
        $finish;
    end

    // Stimulus and final verdict
    initial begin
        t_hsl_item directed[$];
        i_rst_n          = 1'b0;
        hsl_ch.valid     = 1'b0;
        hsl_ch.data      = '0;
        hsl_burst        = 1'b0;
        rgb_burst        = 1'b0;
        rgb_hold_pending = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Ramp segment edges, hue wrap, grey, clamping and the lightness split
        directed = '{make_hsl(0, 1000, 500),   make_hsl(59, 1000, 500),
                     make_hsl(60, 1000, 500),  make_hsl(119, 1000, 500),
                     make_hsl(120, 1000, 500), make_hsl(180, 1000, 500),
                     make_hsl(239, 1000, 500), make_hsl(240, 1000, 500),
                     make_hsl(300, 1000, 500), make_hsl(359, 1000, 500),
                     make_hsl(360, 1000, 500), make_hsl(511, 1000, 500),
                     make_hsl(0, 0, 0),        make_hsl(0, 0, 1000),
                     make_hsl(200, 0, 1023),   make_hsl(90, 0, 333),
                     make_hsl(30, 1023, 250),  make_hsl(150, 500, 1023),
                     make_hsl(210, 1, 499),    make_hsl(270, 999, 500),
                     make_hsl(330, 1000, 1),   make_hsl(45, 1000, 999),
                     make_hsl(255, 511, 512),  make_hsl(256, 512, 511),
                     make_hsl(175, 750, 750)};
        foreach (directed[i])
            send_hsl(directed[i]);

        // Random items in phases of differing idling
        for (int phase = 0; phase < PHASES; phase++) begin
            hsl_burst = (phase % 3 == 0);
            rgb_burst = (phase % 4 == 0);
            if (phase == 4) begin
                hsl_burst        = 1'b1;
                rgb_hold_pending = 1'b1;
            end
            if (phase == 7) begin
                hsl_ch.valid <= 1'b0;
                wait_rgb_drained();
            end
            repeat (PHASE_ITEMS)
                send_hsl(random_hsl());
        end
        hsl_ch.valid <= 1'b0;

        // Let the pipeline empty, then watch for stray results
        wait_rgb_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (tracker.fault_count == 0 && tracker.expected_rgb.size() == 0)
            $display("hsl_to_rgb_converter_tb passed");
        else
            $display("hsl_to_rgb_converter_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
